[src/sconv_pkg.sv]
package sconv_pkg;

  localparam int KERNEL_DEF     = 3;
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_KERNEL     = 4;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 40;
  localparam int FRAC_SHIFT = 14;
  localparam int FEAT_W     = 15;
  localparam int IDX_W      = 8;
  localparam int OUT_DATA_W = 32;

  // positions up to 4095, geometry values up to 4096
  localparam int POS_W    = 12;
  localparam int GEO_W    = POS_W + 1;
  localparam int DIM_W    = 9;
  localparam int STRIDE_W = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int ROW_COEF_W = 64;
  localparam int BIAS_W     = 16;

  localparam int FIFO_DEPTH = 8;

  localparam logic [FEAT_W-1:0] FEAT_MAX    = '1;
  localparam logic [15:0]       THIRD_RECIP = 16'd21846;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_ROW0,
    REG_COEF_ROW1,
    REG_COEF_ROW2,
    REG_COEF_ROW3,
    REG_BIAS,
    REG_STRIDE,
    REG_WIDTH,
    REG_HEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic [GEO_W-1:0]    width;
    logic [GEO_W-1:0]    height;
    logic [STRIDE_W-1:0] stride;
    logic [POS_W-1:0]    last_row;
    logic [POS_W-1:0]    last_col;
  } geom_t;

  typedef struct packed {
    logic             valid;
    logic             emit;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } item_t;

  typedef struct packed {
    logic              last;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  row;
    logic [FEAT_W-1:0] value;
  } result_t;

  typedef struct packed {
    logic [POS_W-1:0] quot;
    logic [1:0]       rem;
  } divmod_t;

  // quotient and remainder by a stride of 1..4; thirds by reciprocal multiply
  function automatic divmod_t div_stride(input logic [POS_W-1:0] x,
                                         input logic [STRIDE_W-1:0] s);
    logic [POS_W+15:0] prod;
    logic [POS_W-1:0]  q;
    logic [POS_W-1:0]  q3;
    divmod_t           d;
    prod = (POS_W+16)'(x) * (POS_W+16)'(THIRD_RECIP);
    q3   = prod[POS_W+15:16];
    unique case (s)
      3'd2: begin
        q = x >> 1;
        d.rem = {1'b0, x[0]};
      end
      3'd3: begin
        q = q3;
        d.rem = 2'(x - (q3 << 1) - q3);
      end
      3'd4: begin
        q = x >> 2;
        d.rem = x[1:0];
      end
      default: begin
        q = x;
        d.rem = 2'd0;
      end
    endcase
    d.quot = q;
    return d;
  endfunction

endpackage

[src/strided_conv2d_relu.sv]
// Strided 2-D convolution with ReLU over a raster-order feature stream.
// s_axis carries one signed Q8.8 sample per transfer in tdata; tuser high
// marks the first sample of a frame and puts it at row 0, column 0.
// m_axis carries one result per transfer for each window that lies on the
// stride grid: ReLU'd Q8.8 value, output row and column; tlast marks the
// last grid position of the frame.
// The cfg channel writes the coefficient rows, bias, stride, width and
// height; it is always ready. It is to be used only while the stream is
// idle; the block itself does not enforce this. Throughput: one sample
// per cycle while s_axis_tready is high. The line store is a single RAM
// read and written once per sample, with a forward path for back-to-back
// hits on the same column; the window MACs are parallel.
// An 8-entry output queue covers the pipeline; when the receiver stalls,
// s_axis_tready drops once queued plus in-flight samples reach 8.
// Reset: position counters cleared, registers to their defaults (stride 1,
// 256 x 256, zero kernel and bias). The line store needs no clearing pass.
module strided_conv2d_relu #(
  parameter int KERNEL     = sconv_pkg::KERNEL_DEF,
  parameter int MAX_WIDTH  = sconv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sconv_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [sconv_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // [15:0] sample_value
  input  logic                                s_axis_tuser,  // [0] frame_start
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [14:0] feature_value, [22:15] out_row, [30:23] out_col, [31] zero
  output logic [sconv_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast,  // frame_last
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sconv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sconv_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import sconv_pkg::*;

  localparam int FIFO_CW = $clog2(FIFO_DEPTH) + 1;
  localparam int PEND_W  = FIFO_CW + 1;

  logic [MAX_KERNEL-1:0][ROW_COEF_W-1:0] coef_rows;
  logic signed [BIAS_W-1:0]              bias;
  logic [STRIDE_W-1:0]                   stride_step;
  logic [DIM_W-1:0]                      frame_width;
  logic [DIM_W-1:0]                      frame_height;
  logic [POS_W-1:0]                      last_row;
  logic [POS_W-1:0]                      last_col;
  divmod_t                               last_row_d;
  divmod_t                               last_col_d;
  geom_t                                 geom;

  logic          in_accept;
  logic          win_busy;
  item_t         item_p2;
  logic [KERNEL*KERNEL*SAMPLE_W-1:0] win_flat;
  logic          res_valid;
  result_t       res;
  logic [1:0]    mac_busy;
  logic [OUT_DATA_W-1:0] pop_data;
  result_t       out_res;
  logic [FIFO_CW-1:0] fifo_count;
  logic [PEND_W-1:0]  pending;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_rows    <= '0;
      bias         <= '0;
      stride_step  <= STRIDE_W'(1);
      frame_width  <= DIM_W'(256);
      frame_height <= DIM_W'(256);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COEF_ROW0: coef_rows[0] <= cfg_data;
        REG_COEF_ROW1: coef_rows[1] <= cfg_data;
        REG_COEF_ROW2: coef_rows[2] <= cfg_data;
        REG_COEF_ROW3: coef_rows[3] <= cfg_data;
        REG_BIAS:      bias         <= cfg_data[BIAS_W-1:0];
        REG_STRIDE:    stride_step  <= cfg_data[STRIDE_W-1:0];
        REG_WIDTH:     frame_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:    frame_height <= cfg_data[DIM_W-1:0];
      endcase
    end
  end

  // effective geometry: zero acts as one, large values saturate
  always_comb begin
    if (stride_step == '0) begin
      geom.stride = STRIDE_W'(1);
    end else if (stride_step > STRIDE_W'(4)) begin
      geom.stride = STRIDE_W'(4);
    end else begin
      geom.stride = stride_step;
    end
    if (frame_width == '0) begin
      geom.width = GEO_W'(1);
    end else if (GEO_W'(frame_width) > GEO_W'(MAX_WIDTH)) begin
      geom.width = GEO_W'(MAX_WIDTH);
    end else begin
      geom.width = GEO_W'(frame_width);
    end
    if (frame_height == '0) begin
      geom.height = GEO_W'(1);
    end else if (GEO_W'(frame_height) > GEO_W'(MAX_HEIGHT)) begin
      geom.height = GEO_W'(MAX_HEIGHT);
    end else begin
      geom.height = GEO_W'(frame_height);
    end
    geom.last_row = last_row;
    geom.last_col = last_col;
  end

  // last grid position; only meaningful when the frame holds a window
  assign last_row_d = div_stride(POS_W'(geom.height - GEO_W'(KERNEL)), geom.stride);
  assign last_col_d = div_stride(POS_W'(geom.width - GEO_W'(KERNEL)), geom.stride);

  always_ff @(posedge clk) begin
    last_row <= last_row_d.quot;
    last_col <= last_col_d.quot;
  end

  // samples in flight plus queued results, all of which may need a slot
  assign pending = PEND_W'(fifo_count) + PEND_W'(win_busy) +
                   PEND_W'(item_p2.valid) + PEND_W'(mac_busy);

  assign s_axis_tready = !rst && (pending < PEND_W'(FIFO_DEPTH));
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  sconv_window #(
    .KERNEL    (KERNEL),
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_window (
    .clk           (clk),
    .rst           (rst),
    .in_accept     (in_accept),
    .in_sample     (s_axis_tdata),
    .in_frame_start(s_axis_tuser),
    .geom          (geom),
    .busy          (win_busy),
    .item          (item_p2),
    .win_flat      (win_flat)
  );

  sconv_mac #(
    .KERNEL(KERNEL)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .item_in  (item_p2),
    .win_flat (win_flat),
    .coef_flat(coef_rows),
    .bias     (bias),
    .res_valid(res_valid),
    .res      (res),
    .busy     (mac_busy)
  );

  sconv_fifo #(
    .WIDTH(OUT_DATA_W),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .push_data(res),
    .pop      (m_axis_tvalid && m_axis_tready),
    .pop_data (pop_data),
    .not_empty(m_axis_tvalid),
    .count    (fifo_count)
  );

  assign out_res      = result_t'(pop_data);
  assign m_axis_tdata = {1'b0, out_res.col, out_res.row, out_res.value};
  assign m_axis_tlast = out_res.last;

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_W'(FIFO_DEPTH))
    else $error("more samples in flight than output queue slots");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (fifo_count != FIFO_CW'(FIFO_DEPTH)) || m_axis_tready)
    else $error("result pushed into a full output queue");

endmodule

[src/sconv_ram.sv]
module sconv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/sconv_fifo.sv]
module sconv_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [WIDTH-1:0]         push_data,
  input  logic                     pop,
  output logic [WIDTH-1:0]         pop_data,
  output logic                     not_empty,
  output logic [$clog2(DEPTH):0]   count
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign pop_data  = mem[rd_ptr];
  assign not_empty = (count != '0);

endmodule

[src/sconv_window.sv]
module sconv_window #(
  parameter int KERNEL     = sconv_pkg::KERNEL_DEF,
  parameter int MAX_WIDTH  = sconv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sconv_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_accept,
  input  logic [sconv_pkg::SAMPLE_W-1:0]               in_sample,
  input  logic                                         in_frame_start,
  input  sconv_pkg::geom_t                             geom,
  output logic                                         busy,
  output sconv_pkg::item_t                             item,
  output logic [KERNEL*KERNEL*sconv_pkg::SAMPLE_W-1:0] win_flat
);

  import sconv_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int LW = (KERNEL > 1) ? (KERNEL - 1) * SAMPLE_W : SAMPLE_W;
  localparam logic [POS_W-1:0] EDGE = POS_W'(KERNEL - 1);

  logic [CW-1:0]    col_count;
  logic [RW-1:0]    row_count;
  logic [GEO_W-1:0] c_cur;
  logic [GEO_W-1:0] r_cur;
  logic [GEO_W-1:0] c_inc;
  logic [GEO_W-1:0] r_inc;
  logic [GEO_W-1:0] col_next;
  logic [GEO_W-1:0] row_next;

  logic                p1_valid;
  logic [SAMPLE_W-1:0] p1_sample;
  logic [POS_W-1:0]    p1_row_pos;
  logic [POS_W-1:0]    p1_col_pos;
  logic                p1_fwd;
  logic [LW-1:0]       p1_fwd_data;

  logic [LW-1:0]       ram_rdata;
  logic [LW-1:0]       line_old;
  logic [LW-1:0]       line_new;
  logic [SAMPLE_W-1:0] column [KERNEL];
  logic [SAMPLE_W-1:0] win [KERNEL][KERNEL];

  logic    row_in;
  logic    col_in;
  divmod_t dr;
  divmod_t dc;
  logic    emit;
  logic    last;

  // position of this sample, with the wraps for frame start and frame end
  always_comb begin
    c_cur = in_frame_start ? '0 : GEO_W'(col_count);
    r_cur = in_frame_start ? '0 : GEO_W'(row_count);
    if (c_cur >= geom.width) begin
      c_cur = '0;
      r_cur = r_cur + 1'b1;
    end
    if (r_cur >= geom.height) begin
      r_cur = '0;
    end
    c_inc    = c_cur + 1'b1;
    r_inc    = r_cur + 1'b1;
    col_next = c_inc;
    row_next = r_cur;
    if (c_inc >= geom.width) begin
      col_next = '0;
      row_next = (r_inc >= geom.height) ? '0 : r_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      p1_valid  <= 1'b0;
    end else begin
      p1_valid <= in_accept;
      if (in_accept) begin
        col_count <= col_next[CW-1:0];
        row_count <= row_next[RW-1:0];
      end
    end
    if (in_accept) begin
      p1_sample   <= in_sample;
      p1_row_pos  <= POS_W'(r_cur);
      p1_col_pos  <= POS_W'(c_cur);
      // column written back this cycle is not in the RAM read yet
      p1_fwd      <= p1_valid && (p1_col_pos[CW-1:0] == c_cur[CW-1:0]);
      p1_fwd_data <= line_new;
    end
  end

  generate
    if (KERNEL > 1) begin : g_line
      sconv_ram #(
        .WIDTH(LW),
        .DEPTH(MAX_WIDTH)
      ) u_line (
        .clk   (clk),
        .we    (p1_valid),
        .waddr (p1_col_pos[CW-1:0]),
        .wdata (line_new),
        .re    (in_accept),
        .raddr (c_cur[CW-1:0]),
        .rdata (ram_rdata)
      );
    end else begin : g_no_line
      assign ram_rdata = '0;
    end
  endgenerate

  // slot 0 holds the newest line; shift rows down and insert this sample
  assign line_old = p1_fwd ? p1_fwd_data : ram_rdata;
  assign line_new = LW'({line_old, p1_sample});

  always_comb begin
    for (int i = 0; i < KERNEL - 1; i++) begin
      column[i] = line_old[(KERNEL-2-i)*SAMPLE_W +: SAMPLE_W];
    end
    column[KERNEL-1] = p1_sample;
  end

  always_ff @(posedge clk) begin
    if (p1_valid) begin
      for (int i = 0; i < KERNEL; i++) begin
        for (int j = 0; j < KERNEL - 1; j++) begin
          win[i][j] <= win[i][j+1];
        end
        win[i][KERNEL-1] <= column[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < KERNEL; i++) begin
      for (int j = 0; j < KERNEL; j++) begin
        win_flat[(i*KERNEL+j)*SAMPLE_W +: SAMPLE_W] = win[i][j];
      end
    end
  end

  // stride grid check on the window's bottom-right corner
  always_comb begin
    row_in = (p1_row_pos >= EDGE);
    col_in = (p1_col_pos >= EDGE);
    dr     = div_stride(p1_row_pos - EDGE, geom.stride);
    dc     = div_stride(p1_col_pos - EDGE, geom.stride);
    emit   = row_in && col_in && (dr.rem == 2'd0) && (dc.rem == 2'd0);
    last   = (dr.quot == geom.last_row) && (dc.quot == geom.last_col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      item.valid <= p1_valid;
    end
    if (p1_valid) begin
      item.emit <= emit;
      item.last <= last;
      item.row  <= dr.quot[IDX_W-1:0];
      item.col  <= dc.quot[IDX_W-1:0];
    end
  end

  assign busy = p1_valid;

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    $past(in_accept) && $stable(geom.width) |-> GEO_W'(col_count) < geom.width)
    else $error("column counter past frame width");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    $past(in_accept) && $stable(geom.height) |-> GEO_W'(row_count) < geom.height)
    else $error("row counter past frame height");

endmodule

[src/sconv_mac.sv]
module sconv_mac #(
  parameter int KERNEL = sconv_pkg::KERNEL_DEF
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  sconv_pkg::item_t                                        item_in,
  input  logic [KERNEL*KERNEL*sconv_pkg::SAMPLE_W-1:0]            win_flat,
  input  logic [sconv_pkg::MAX_KERNEL*sconv_pkg::ROW_COEF_W-1:0]  coef_flat,
  input  logic signed [sconv_pkg::BIAS_W-1:0]                     bias,
  output logic                                                    res_valid,
  output sconv_pkg::result_t                                      res,
  output logic [1:0]                                              busy
);

  import sconv_pkg::*;

  localparam int SH_W = ACC_W - FRAC_SHIFT;

  item_t item3;
  item_t item4;
  item_t item5;

  logic signed [PROD_W-1:0] prod [KERNEL*KERNEL];
  logic signed [ACC_W-1:0]  rsum_c [KERNEL];
  logic signed [ACC_W-1:0]  rsum [KERNEL];
  logic signed [ACC_W-1:0]  acc_c;
  logic signed [ACC_W-1:0]  acc;
  logic [SH_W-1:0]          acc_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      item3.valid <= 1'b0;
      item4.valid <= 1'b0;
      item5.valid <= 1'b0;
    end else begin
      item3.valid <= item_in.valid;
      item4.valid <= item3.valid;
      item5.valid <= item4.valid;
    end
    if (item_in.valid) begin
      {item3.emit, item3.last, item3.row, item3.col} <=
        {item_in.emit, item_in.last, item_in.row, item_in.col};
      for (int i = 0; i < KERNEL; i++) begin
        for (int j = 0; j < KERNEL; j++) begin
          prod[i*KERNEL+j] <=
            $signed(win_flat[(i*KERNEL+j)*SAMPLE_W +: SAMPLE_W]) *
            $signed(coef_flat[i*ROW_COEF_W + j*COEF_W +: COEF_W]);
        end
      end
    end
    if (item3.valid) begin
      {item4.emit, item4.last, item4.row, item4.col} <=
        {item3.emit, item3.last, item3.row, item3.col};
      rsum <= rsum_c;
    end
    if (item4.valid) begin
      {item5.emit, item5.last, item5.row, item5.col} <=
        {item4.emit, item4.last, item4.row, item4.col};
      acc <= acc_c;
    end
  end

  always_comb begin
    for (int i = 0; i < KERNEL; i++) begin
      rsum_c[i] = '0;
      for (int j = 0; j < KERNEL; j++) begin
        rsum_c[i] = rsum_c[i] + ACC_W'(prod[i*KERNEL+j]);
      end
    end
  end

  always_comb begin
    acc_c = ACC_W'(bias) <<< FRAC_SHIFT;
    for (int i = 0; i < KERNEL; i++) begin
      acc_c = acc_c + rsum[i];
    end
  end

  // ReLU, drop fraction bits, saturate
  always_comb begin
    acc_sh = acc[ACC_W-1:FRAC_SHIFT];
    if (acc <= 0) begin
      res.value = '0;
    end else if (acc_sh > SH_W'(FEAT_MAX)) begin
      res.value = FEAT_MAX;
    end else begin
      res.value = acc_sh[FEAT_W-1:0];
    end
    res.row  = item5.row;
    res.col  = item5.col;
    res.last = item5.last;
  end

  assign res_valid = item5.valid && item5.emit;
  assign busy      = 2'(item3.valid) + 2'(item4.valid) + 2'(item5.valid);

endmodule
